[rtl/core/debounced_button_hold_repeat_defines.svh]
// ---------------------------------------------------------------------------
// debounced_button_hold_repeat_defines.svh
// Assertion macros used by the button debounce / auto-repeat RTL.
// ---------------------------------------------------------------------------
`ifndef DEBOUNCED_BUTTON_HOLD_REPEAT_DEFINES_SVH
`define DEBOUNCED_BUTTON_HOLD_REPEAT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define DBHR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define DBHR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/dbhr_pkg.sv]
// ---------------------------------------------------------------------------
// dbhr_pkg
// Widths, register indexes, reset values and event codes for the button
// debounce / auto-repeat block.
// ---------------------------------------------------------------------------
package dbhr_pkg;

   // Field widths
   localparam int NOW_BITS       = 32;
   localparam int CFG_BITS       = 16;
   localparam int EV_BITS        = 9;
   localparam int CSR_INDEX_BITS = 2;

   // Default timestamp width inside the block
   localparam int TIME_BITS_DEFAULT = 32;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEBOUNCE      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HOLD_INTERVAL = 2'd1;

   // Register reset values
   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET      = 16'd50;
   localparam logic [CFG_BITS-1:0] HOLD_INTERVAL_RESET = 16'd500;

   // Event codes
   localparam logic signed [EV_BITS-1:0] EV_NONE    = 9'sd0;
   localparam logic signed [EV_BITS-1:0] EV_PRESS   = 9'sd1;
   localparam logic signed [EV_BITS-1:0] EV_RELEASE = -9'sd1;
   localparam logic signed [EV_BITS-1:0] EV_MAX     = 9'sd255;

   // Quotient at or above this saturates the repeat count
   localparam logic [7:0] REPEAT_SAT_Q = 8'd254;

   // Switch levels
   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

endpackage

[rtl/core/debounced_button_hold_repeat.sv]
// ---------------------------------------------------------------------------
// debounced_button_hold_repeat
// Debounces a polled active-low switch and produces press, release and
// hold auto-repeat events; repeat counts come from a serial divider.
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_switch_level, req_now_ms
//   rsp      out        rsp_valid/rsp_stall rsp_event_value
//   csr      in         csr_valid/csr_ready csr_index, csr_wdata
//
// Each poll gives exactly one result beat.
// A poll passes through accept, evaluate and write out, with a divide step before write out
// when a hold repeat is due: the restoring divider retires one quotient bit a cycle.
// req_stall is high from accept until the result is loaded into the output
// register; a stalled output register holds the poll in the write state.
// Synchronous active-high reset restores the register defaults and the
// released-switch state. csr_ready is always high.
// ---------------------------------------------------------------------------
`include "debounced_button_hold_repeat_defines.svh"

module debounced_button_hold_repeat #(
   parameter int TIME_BITS = dbhr_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // poll input
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_switch_level,
   input  logic [dbhr_pkg::NOW_BITS-1:0]             req_now_ms,
   // event output
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [dbhr_pkg::EV_BITS-1:0]       rsp_event_value,
   // register writes
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [dbhr_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [dbhr_pkg::CFG_BITS-1:0]             csr_wdata
);

   localparam int CNT_BITS = $clog2(TIME_BITS + 1);
   localparam int CB       = dbhr_pkg::CFG_BITS;
   localparam int EB       = dbhr_pkg::EV_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   state_type                state_ff, state_in;
   logic                     level_ff, level_in;
   logic [TIME_BITS-1:0]     now_ff, now_in;
   logic                     accepted_ff, accepted_in;
   logic [TIME_BITS-1:0]     change_time_ff, change_time_in;
   logic                     holding_ff, holding_in;
   logic [TIME_BITS-1:0]     lre_ff, lre_in;
   logic [CB-1:0]            debounce_ff, debounce_in;
   logic [CB-1:0]            interval_ff, interval_in;
   logic [TIME_BITS-1:0]     quo_ff, quo_in;
   logic [CB-1:0]            rem_ff, rem_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic signed [EB-1:0]     ev_ff, ev_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [EB-1:0]     rsp_event_ff, rsp_event_in;

   // Shared divider step and evaluation terms
   logic [CB-1:0]            iv;
   logic [TIME_BITS-1:0]     elapsed;
   logic [TIME_BITS-1:0]     since_report;
   logic [CB:0]              trial;
   logic                     trial_ge;
   logic [CB-1:0]            rem_step;
   logic [TIME_BITS-1:0]     quo_step;
   logic                     quo_sat;
   logic signed [EB-1:0]     repeat_ev;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_value = rsp_event_ff;
   assign csr_ready       = 1'b1;

   // A zero interval counts as one
   assign iv = (interval_ff == '0) ? CB'(1) : interval_ff;

   assign elapsed      = now_ff - change_time_ff;
   assign since_report = elapsed - lre_ff;

   // Restoring divide step: one quotient bit per cycle
   assign trial    = {rem_ff, quo_ff[TIME_BITS-1]};
   assign trial_ge = (trial >= {1'b0, iv});
   assign rem_step = trial_ge ? CB'(trial - {1'b0, iv}) : trial[CB-1:0];
   assign quo_step = {quo_ff[TIME_BITS-2:0], trial_ge};

   // Repeat count 1 + q, saturated
   assign quo_sat   = (|quo_step[TIME_BITS-1:8]) || (quo_step[7:0] >= dbhr_pkg::REPEAT_SAT_Q);
   assign repeat_ev = quo_sat ? dbhr_pkg::EV_MAX : $signed({1'b0, quo_step[7:0] + 8'd1});

   // Sequencer and datapath next values
   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      now_in         = now_ff;
      accepted_in    = accepted_ff;
      change_time_in = change_time_ff;
      holding_in     = holding_ff;
      lre_in         = lre_ff;
      debounce_in    = debounce_ff;
      interval_in    = interval_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      count_in       = count_ff;
      ev_in          = ev_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_event_in   = rsp_event_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            dbhr_pkg::REG_DEBOUNCE:      debounce_in = csr_wdata;
            dbhr_pkg::REG_HOLD_INTERVAL: interval_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               level_in = req_switch_level;
               now_in   = TIME_BITS'(req_now_ms);
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ev_in    = dbhr_pkg::EV_NONE;
            state_in = ST_WRITE;
            if (level_ff != accepted_ff) begin
               if (elapsed > TIME_BITS'(debounce_ff)) begin
                  if (level_ff == dbhr_pkg::LEVEL_PRESSED) begin
                     ev_in      = dbhr_pkg::EV_PRESS;
                     holding_in = 1'b1;
                     lre_in     = '0;
                  end else begin
                     ev_in      = dbhr_pkg::EV_RELEASE;
                     holding_in = 1'b0;
                  end
                  accepted_in    = level_ff;
                  change_time_in = now_ff;
               end
            end else if (holding_ff && (elapsed > lre_ff) &&
                         (since_report > TIME_BITS'(iv))) begin
               lre_in   = elapsed;
               quo_in   = elapsed;
               rem_in   = '0;
               count_in = CNT_BITS'(TIME_BITS);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            quo_in   = quo_step;
            rem_in   = rem_step;
            count_in = count_ff - CNT_BITS'(1);
            if (count_ff == CNT_BITS'(1)) begin
               ev_in    = repeat_ev;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = ev_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         accepted_ff    <= dbhr_pkg::LEVEL_RELEASED;
         change_time_ff <= '0;
         holding_ff     <= 1'b0;
         lre_ff         <= '0;
         debounce_ff    <= dbhr_pkg::DEBOUNCE_RESET;
         interval_ff    <= dbhr_pkg::HOLD_INTERVAL_RESET;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         accepted_ff    <= accepted_in;
         change_time_ff <= change_time_in;
         holding_ff     <= holding_in;
         lre_ff         <= lre_in;
         debounce_ff    <= debounce_in;
         interval_ff    <= interval_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      level_ff     <= level_in;
      now_ff       <= now_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      ev_ff        <= ev_in;
      rsp_event_ff <= rsp_event_in;
   end

   // Checks
   `DBHR_ASSERT_IMP(a_hold_matches_level, clock, reset, 1'b1, holding_ff != accepted_ff, "holding out of step with accepted level")
   `DBHR_ASSERT_NXT(a_divide_counts_down, clock, reset, state_ff == ST_DIVIDE, (state_ff == ST_WRITE) || ((state_ff == ST_DIVIDE) && (count_ff == $past(count_ff) - CNT_BITS'(1))), "divider count did not step")
   `DBHR_ASSERT_IMP(a_rem_below_divisor, clock, reset, state_ff == ST_DIVIDE, rem_ff < iv, "partial remainder not below divisor")
   `DBHR_ASSERT_IMP(a_rsp_from_write, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_WRITE, "result beat raised outside write state")

endmodule
